// ===== rtl/core/ohss_pkg.sv =====
`default_nettype none

package ohss_pkg;

	// fixed field widths
	localparam int STEP_W     = 8;
	localparam int HOLE_SEL_W = 3;
	localparam int MASK_OUT_W = 8;
	localparam int THRESH_W   = 12;
	localparam int REST_W     = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COVER_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_TICKS      = 1'd1;

	// configuration reset values
	localparam logic [THRESH_W-1:0] COVER_THRESHOLD_RST = 12'd500;
	localparam logic [REST_W-1:0]   REST_TICKS_RST      = 8'd16;

	// scan phase codes
	localparam logic [1:0] PH_REST = 2'd0;
	localparam logic [1:0] PH_DARK = 2'd1;
	localparam logic [1:0] PH_LIT  = 2'd2;

	// one result transaction
	typedef struct packed {
		logic [HOLE_SEL_W-1:0] hole_select;
		logic                  emitter_enable;
		logic                  cycle_done;
		logic [MASK_OUT_W-1:0] hole_mask;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ohss_out_buf.sv =====
`default_nettype none

// Two-entry output buffer: the main register drives the port, the skid
// register catches a transaction that arrives while the port is stalled.
module ohss_out_buf import ohss_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push_valid,
	output logic         push_ready,
	input  wire result_t push_data,
	output logic         pop_valid,
	input  wire logic    pop_ready,
	output result_t      pop_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    push;
	logic    pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign pop        = main_valid_q && pop_ready;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (main_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/optical_hole_scan_sequencer.sv =====
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+------------------------------------
// sample    | in        | sample_valid / sample_ready | sample
// result    | out       | result_valid / result_ready | hole_select, emitter_enable,
//           |           |                             | cycle_done, hole_mask
// config    | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// Each sample transaction yields one result transaction, registered in the
// output buffer; one sample per cycle is taken while sample_ready is high.
// The two-entry output buffer holds a result in its skid register while the
// result port stalls; sample_ready drops only once both entries are full.
// Reset clears phase, step count and differences and loads the configuration reset values.
module optical_hole_scan_sequencer import ohss_pkg::*; #(
	parameter int HOLE_COUNT  = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   sample_valid,
	output logic                        sample_ready,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output logic [HOLE_SEL_W-1:0]       hole_select,
	output logic                        emitter_enable,
	output logic                        cycle_done,
	output logic [MASK_OUT_W-1:0]       hole_mask,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W  = (HOLE_COUNT > 1) ? $clog2(HOLE_COUNT) : 1;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int CMP_W  = ((DIFF_W > THRESH_W + 1) ? DIFF_W : THRESH_W + 1) + 1;
	localparam int MASK_W = (HOLE_COUNT > MASK_OUT_W) ? HOLE_COUNT : MASK_OUT_W;
	localparam logic [STEP_W-1:0] HOLES = STEP_W'(HOLE_COUNT);

	logic [THRESH_W-1:0]    cover_threshold_q;
	logic [REST_W-1:0]      rest_ticks_q;
	logic [1:0]             phase_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS-1:0] dark_q [HOLE_COUNT];
	logic [DIFF_W-1:0]      diff_q [HOLE_COUNT];

	logic                   push;
	logic [1:0]             phase_n;
	logic [STEP_W-1:0]      step_n;
	logic [STEP_W-1:0]      rest_base;
	logic [STEP_W-1:0]      rest_inc;
	logic [STEP_W-1:0]      hole_inc;
	logic [IDX_W-1:0]       idx;
	logic                   idx_ok;
	logic                   dark_wr;
	logic                   diff_wr;
	logic [DIFF_W-1:0]      diff_new;
	logic [MASK_W-1:0]      mask_all;
	result_t                res_n;
	result_t                res_out;

	assign push     = sample_valid && sample_ready;
	assign idx      = step_q[IDX_W-1:0];
	assign idx_ok   = step_q < HOLES;
	assign dark_wr  = push && (phase_q == PH_DARK) && idx_ok;
	assign diff_wr  = push && (phase_q == PH_LIT) && idx_ok;
	assign diff_new = {1'b0, dark_q[idx]} - {1'b0, sample};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_threshold_q <= COVER_THRESHOLD_RST;
			rest_ticks_q      <= REST_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COVER_THRESHOLD: cover_threshold_q <= cfg_data[THRESH_W-1:0];
				REG_REST_TICKS:      rest_ticks_q      <= cfg_data[REST_W-1:0];
				default: ;
			endcase
		end
	end

	// next phase and step count
	always_comb begin
		rest_base = (phase_q == PH_REST) ? step_q : '0;
		rest_inc  = rest_base + STEP_W'(1);
		hole_inc  = step_q + STEP_W'(1);
		phase_n   = phase_q;
		step_n    = hole_inc;
		priority if (phase_q == PH_DARK) begin
			if (hole_inc >= HOLES) begin
				phase_n = PH_LIT;
				step_n  = '0;
			end
		end else if (phase_q == PH_LIT) begin
			if (hole_inc >= HOLES) begin
				phase_n = PH_REST;
				step_n  = '0;
			end
		end else begin
			// resting, or an unused code that restarts the rest count
			phase_n = PH_REST;
			step_n  = rest_inc;
			if (rest_inc >= STEP_W'(rest_ticks_q) || rest_inc == '0) begin
				phase_n = PH_DARK;
				step_n  = '0;
			end
		end
	end

	// covered-hole mask, seen after this transaction's store
	always_comb begin
		logic [DIFF_W-1:0]       d;
		logic signed [CMP_W-1:0] dx;
		logic signed [CMP_W-1:0] tx;
		mask_all = '0;
		tx       = $signed(CMP_W'(cover_threshold_q));
		for (int k = 0; k < HOLE_COUNT; k++) begin
			d  = (diff_wr && idx == IDX_W'(k)) ? diff_new : diff_q[k];
			dx = CMP_W'($signed(d));
			mask_all[k] = dx > tx;
		end
	end

	// result fields
	always_comb begin
		res_n.hole_select    = (phase_n == PH_REST) ? '0 : step_n[HOLE_SEL_W-1:0];
		res_n.emitter_enable = phase_n == PH_LIT;
		res_n.cycle_done     = (phase_n == PH_REST) && (step_n == '0);
		res_n.hole_mask      = mask_all[MASK_OUT_W-1:0];
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REST;
			step_q  <= '0;
		end else if (push) begin
			phase_q <= phase_n;
			step_q  <= step_n;
		end
	end

	// dark readings, no reset, valid once written
	always_ff @(posedge clk) begin
		if (dark_wr) begin
			dark_q[idx] <= sample;
		end
	end

	// differences, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HOLE_COUNT; k++) begin
				diff_q[k] <= '0;
			end
		end else if (diff_wr) begin
			diff_q[idx] <= diff_new;
		end
	end

	ohss_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sample_valid),
		.push_ready (sample_ready),
		.push_data  (res_n),
		.pop_valid  (result_valid),
		.pop_ready  (result_ready),
		.pop_data   (res_out)
	);

	assign hole_select    = res_out.hole_select;
	assign emitter_enable = res_out.emitter_enable;
	assign cycle_done     = res_out.cycle_done;
	assign hole_mask      = res_out.hole_mask;

	// sampling phases never run past the last hole
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DARK || phase_q == PH_LIT) |-> step_q < HOLES)
		else $error("step count past last hole");

	// a finished scan only comes out of the lit phase
	a_done_from_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res_n.cycle_done) |-> phase_q == PH_LIT)
		else $error("cycle_done outside lit phase");

	// last dark sample hands over to the lit phase with emitters on
	a_dark_to_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(push && phase_q == PH_DARK && step_q == HOLES - STEP_W'(1))
		|=> (phase_q == PH_LIT && step_q == '0))
		else $error("dark phase did not hand over to lit phase");

endmodule

`default_nettype wire

// ===== test/optical_hole_scan_sequencer_checker.sv =====
// Scoreboard for the hole scan sequencer: mirrors the scan state, predicts one
// result per sample transaction and compares result transactions in order.
module optical_hole_scan_sequencer_checker import ohss_pkg::*; #(
	parameter int HOLE_COUNT  = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  logic [HOLE_SEL_W-1:0]  hole_select,
	input  logic                   emitter_enable,
	input  logic                   cycle_done,
	input  logic [MASK_OUT_W-1:0]  hole_mask,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     failures,
	output int                     outstanding
);

	localparam int IDX_W = (HOLE_COUNT > 1) ? $clog2(HOLE_COUNT) : 1;

	// mirrored scan state and configuration
	logic [1:0]                  scan_phase;
	logic [STEP_W-1:0]           step;
	logic [THRESH_W-1:0]         threshold;
	logic [REST_W-1:0]           rest_len;
	logic [SAMPLE_BITS-1:0]      dark_level [HOLE_COUNT];
	logic signed [SAMPLE_BITS:0] hole_diff [HOLE_COUNT];
	result_t                     awaited_results [$];
	int                          mismatches = 0;

	task automatic log_mismatch(input string msg);
		$display("%0t scan mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// one tick of the scan; returns the result the block should emit for it
	function automatic result_t advance_scan(input logic [SAMPLE_BITS-1:0] s);
		result_t r;
		r = '0;
		case (scan_phase)
			PH_DARK: begin
				dark_level[step[IDX_W-1:0]] = s;
				step = step + 1'b1;
				if (step >= HOLE_COUNT) begin
					scan_phase = PH_LIT;
					step = '0;
				end
			end
			PH_LIT: begin
				// dark minus lit, one bit wider so it never wraps
				hole_diff[step[IDX_W-1:0]] = $signed({1'b0, dark_level[step[IDX_W-1:0]]})
					- $signed({1'b0, s});
				step = step + 1'b1;
				if (step >= HOLE_COUNT) begin
					scan_phase = PH_REST;
					step = '0;
				end
			end
			default: begin
				// resting: sample ignored; a stray phase code restarts the count
				if (scan_phase != PH_REST) begin
					scan_phase = PH_REST;
					step = '0;
				end
				step = step + 1'b1;
				if (step >= rest_len || step == '0) begin
					scan_phase = PH_DARK;
					step = '0;
				end
			end
		endcase
		for (int k = 0; k < HOLE_COUNT; k++)
			if (hole_diff[k] > $signed({1'b0, threshold}))
				r.hole_mask[k] = 1'b1;
		r.hole_select    = (scan_phase == PH_REST) ? '0 : step[HOLE_SEL_W-1:0];
		r.emitter_enable = (scan_phase == PH_LIT);
		r.cycle_done     = (scan_phase == PH_REST) && (step == '0);
		return r;
	endfunction

	task automatic check_result();
		result_t want;
		if (awaited_results.size() == 0) begin
			log_mismatch("result transaction with nothing awaited");
		end else begin
			want = awaited_results.pop_front();
			if (hole_select !== want.hole_select)
				log_mismatch($sformatf("hole_select got %0d want %0d",
					hole_select, want.hole_select));
			if (emitter_enable !== want.emitter_enable)
				log_mismatch($sformatf("emitter_enable got %0d want %0d",
					emitter_enable, want.emitter_enable));
			if (cycle_done !== want.cycle_done)
				log_mismatch($sformatf("cycle_done got %0d want %0d",
					cycle_done, want.cycle_done));
			if (hole_mask !== want.hole_mask)
				log_mismatch($sformatf("hole_mask got %02h want %02h",
					hole_mask, want.hole_mask));
		end
	endtask

	// results are checked before the same edge's sample is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_phase = PH_REST;
			step       = '0;
			threshold  = COVER_THRESHOLD_RST;
			rest_len   = REST_TICKS_RST;
			for (int k = 0; k < HOLE_COUNT; k++) begin
				dark_level[k] = '0;
				hole_diff[k]  = '0;
			end
			awaited_results.delete();
		end else begin
			if (result_valid && result_ready)
				check_result();
			if (sample_valid && sample_ready)
				awaited_results.push_back(advance_scan(sample));
			if (cfg_we) begin
				case (cfg_index)
					REG_COVER_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
					REG_REST_TICKS:      rest_len  = cfg_data[REST_W-1:0];
					default: ;
				endcase
			end
		end
		outstanding <= awaited_results.size();
		failures    <= mismatches;
	end

endmodule

// ===== test/optical_hole_scan_sequencer_tb.sv =====
module optical_hole_scan_sequencer_tb;
	import ohss_pkg::*;

	localparam int SAMPLE_W   = 12;
	localparam int IDLE_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n         = 1'b0;
	logic                  sample_valid   = 1'b0;
	logic                  sample_ready;
	logic [SAMPLE_W-1:0]   sample         = '0;
	logic                  result_valid;
	logic                  result_ready   = 1'b0;
	logic [HOLE_SEL_W-1:0] hole_select;
	logic                  emitter_enable;
	logic                  cycle_done;
	logic [MASK_OUT_W-1:0] hole_mask;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = REG_COVER_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	int failures;
	int outstanding;
	int tx_gap_max  = 15;
	int rx_gap_max  = 15;
	int idle_cycles = 0;

	// settings walked through after the directed part; the rest go random
	int fixed_thr  [6] = '{500, 4095, 0, 1, 2048, 4094};
	int fixed_rest [6] = '{16, 255, 1, 2, 3, 0};

	// one rest tick, then dark and lit passes with extreme readings
	logic [SAMPLE_W-1:0] directed_readings [18] = '{
		12'hABC,
		12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1, 12'd4094, 12'd2048, 12'd2047,
		12'd0, 12'd4095, 12'd4094, 12'd1, 12'd0, 12'd4095, 12'd2047, 12'd2048,
		12'h555
	};

	optical_hole_scan_sequencer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.hole_select    (hole_select),
		.emitter_enable (emitter_enable),
		.cycle_done     (cycle_done),
		.hole_mask      (hole_mask),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	optical_hole_scan_sequencer_checker scan_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.hole_select    (hole_select),
		.emitter_enable (emitter_enable),
		.cycle_done     (cycle_done),
		.hole_mask      (hole_mask),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// readings skewed toward bright and dark so differences straddle the threshold
	function automatic logic [SAMPLE_W-1:0] pick_reading();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			3:       return SAMPLE_W'($urandom_range(3000, 4095));
			4:       return SAMPLE_W'($urandom_range(0, 1000));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// one sample transaction; valid stays up across back-to-back items
	task automatic push_reading(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= v;
		do @(posedge clk); while (!sample_ready);
	endtask

	// caller drops cfg_we after the last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic drain_results();
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random stall before each transaction
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, rx_gap_max);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int cover_thr;
		int rest_cnt;
		int n_items;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: threshold zero, rest length zero with junk in the upper data bits
		cfg_write(REG_COVER_THRESHOLD, '0);
		cfg_write(REG_REST_TICKS, 12'hF00);
		cfg_we <= 1'b0;
		foreach (directed_readings[i])
			push_reading(directed_readings[i]);
		sample_valid <= 1'b0;

		// random phases, each under its own configuration
		for (int p = 0; p < 12; p++) begin
			if (p < 6) begin
				cover_thr = fixed_thr[p];
				rest_cnt  = fixed_rest[p];
			end else begin
				cover_thr = $urandom_range(0, 4095);
				rest_cnt  = $urandom_range(0, 12);
			end
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;

			drain_results();
			repeat (2) @(posedge clk);
			if ($urandom_range(0, 1)) begin
				cfg_write(REG_COVER_THRESHOLD, CFG_DATA_W'(cover_thr));
				cfg_write(REG_REST_TICKS, {4'($urandom), 8'(rest_cnt)});
			end else begin
				cfg_write(REG_REST_TICKS, {4'($urandom), 8'(rest_cnt)});
				cfg_write(REG_COVER_THRESHOLD, CFG_DATA_W'(cover_thr));
			end
			cfg_we <= 1'b0;

			// a 255-tick rest needs a long phase to get through one scan
			n_items = (rest_cnt == 255) ? 300 : 40;
			repeat (n_items) push_reading(pick_reading());
			sample_valid <= 1'b0;
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
